>>> rtl/geosphere_face_triangle_indexer_assert.svh
// Assertion macros shared by the triangle indexer RTL.
// Needs clk and rst_n in scope at the point of use.
`ifndef GEOSPHERE_FACE_TRIANGLE_INDEXER_ASSERT_SVH
`define GEOSPHERE_FACE_TRIANGLE_INDEXER_ASSERT_SVH
`ifndef SYNTHESIS
// Condition must hold in the same cycle as the trigger
`define GFTI_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");
// Condition must hold in the cycle after the trigger
`define GFTI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");
`else
`define GFTI_ASSERT_SAME(lbl, ante, cons)
`define GFTI_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/gfti_pkg.sv
// Shared types and constants for the geosphere face triangle indexer.
// No dependencies.
package gfti_pkg;

    // field widths
    localparam int TN_W   = 16;
    localparam int BASE_W = 17;
    localparam int IDX_W  = 18;
    localparam int RES_W  = 4;

    // default depth of the digit chain and reset subdivision level
    localparam int             DEFAULT_MAX_LEVEL = 8;
    localparam logic [RES_W-1:0] RES_RESET       = 4'd5;

    // one base-4 digit of the triangle number picks a sub-triangle
    typedef enum logic [1:0] {
        DIG_BASE  = 2'd0,   // copy at origin
        DIG_UP    = 2'd1,   // copy shifted along y
        DIG_MID   = 2'd2,   // point-reflected centre copy
        DIG_RIGHT = 2'd3    // copy shifted along x
    } digit_t;

endpackage

>>> rtl/gfti_if.sv
// Valid/ready channel interfaces for input and result words.
// Depends on gfti_pkg.
interface gfti_item_if import gfti_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TN_W-1:0]   triangle_number;
    logic [BASE_W-1:0] base_index;

    modport source (output valid, output triangle_number, output base_index, input ready);
    modport sink   (input valid, input triangle_number, input base_index, output ready);
endinterface

interface gfti_result_if import gfti_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] corner_a_index;
    logic [IDX_W-1:0] corner_b_index;
    logic [IDX_W-1:0] corner_c_index;
    logic [IDX_W-1:0] next_base_index;

    modport source (output valid, output corner_a_index, output corner_b_index,
                    output corner_c_index, output next_base_index, input ready);
    modport sink   (input valid, input corner_a_index, input corner_b_index,
                    input corner_c_index, input next_base_index, output ready);
endinterface

>>> rtl/gfti_cell.sv
// One digit cell of the subdivision chain: applies one base-4 digit to the corners.
// Depends on gfti_pkg and the assertion macro header.
`include "geosphere_face_triangle_indexer_assert.svh"

module gfti_cell
    import gfti_pkg::*;
#(
    parameter int MAX_LEVEL = DEFAULT_MAX_LEVEL,
    parameter int IDX       = 0
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [$clog2(MAX_LEVEL+1)-1:0]    lvl,
    input  logic                              up_valid,
    output logic                              up_ready,
    input  logic [TN_W-1:0]                   up_tn,
    input  logic [BASE_W-1:0]                 up_base,
    input  logic [2:0][MAX_LEVEL:0]           up_x,
    input  logic [2:0][MAX_LEVEL:0]           up_y,
    output logic                              dn_valid,
    input  logic                              dn_ready,
    output logic [TN_W-1:0]                   dn_tn,
    output logic [BASE_W-1:0]                 dn_base,
    output logic [2:0][MAX_LEVEL:0]           dn_x,
    output logic [2:0][MAX_LEVEL:0]           dn_y
);

    localparam int             CW    = MAX_LEVEL + 1;
    localparam int             LVL_W = $clog2(MAX_LEVEL + 1);
    localparam logic [CW-1:0]  STEP  = CW'(1) << IDX;
    localparam logic [CW:0]    BOUND = (CW + 1)'(1) << (IDX + 1);

    logic                   valid_reg, valid_next;
    logic [TN_W-1:0]        tn_reg;
    logic [BASE_W-1:0]      base_reg;
    logic [2:0][CW-1:0]     x_reg, x_next;
    logic [2:0][CW-1:0]     y_reg, y_next;
    digit_t                 digit;
    logic                   active;

    // pick this cell's digit; digits past the field width are zero
    generate
        if (2 * IDX + 1 < TN_W) begin : g_digit
            assign digit = digit_t'(up_tn[2*IDX +: 2]);
        end else begin : g_no_digit
            assign digit = DIG_BASE;
        end
    endgenerate

    assign active   = lvl > LVL_W'(IDX);
    assign up_ready = !valid_reg || dn_ready;

    // sub-triangle placement at this scale
    always_comb
    begin
        x_next = up_x;
        y_next = up_y;
        if (active)
        begin
            for (int c = 0; c < 3; c++)
            begin
                unique case (digit)
                    DIG_BASE:
                    begin
                        x_next[c] = up_x[c];
                        y_next[c] = up_y[c];
                    end
                    DIG_UP:
                    begin
                        x_next[c] = up_x[c];
                        y_next[c] = up_y[c] + STEP;
                    end
                    DIG_MID:
                    begin
                        x_next[c] = STEP - up_x[c];
                        y_next[c] = STEP - up_y[c];
                    end
                    DIG_RIGHT:
                    begin
                        x_next[c] = up_x[c] + STEP;
                        y_next[c] = up_y[c];
                    end
                endcase
            end
        end
    end

    assign valid_next = up_ready ? up_valid : valid_reg;

    // handshake state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // word registers
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            tn_reg   <= up_tn;
            base_reg <= up_base;
            x_reg    <= x_next;
            y_reg    <= y_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_tn    = tn_reg;
    assign dn_base  = base_reg;
    assign dn_x     = x_reg;
    assign dn_y     = y_reg;

    // every corner lies inside the triangle of twice this cell's scale
    `GFTI_ASSERT_SAME(a_cell_bound, valid_reg, ((CW+1)'(x_reg[0]) + (CW+1)'(y_reg[0]) <= BOUND) && ((CW+1)'(x_reg[1]) + (CW+1)'(y_reg[1]) <= BOUND) && ((CW+1)'(x_reg[2]) + (CW+1)'(y_reg[2]) <= BOUND))
    // a stalled word holds in the cell
    `GFTI_ASSERT_NEXT(a_cell_hold, valid_reg && !dn_ready, valid_reg && $stable(x_reg) && $stable(y_reg) && $stable(base_reg))

endmodule

>>> rtl/gfti_index.sv
// Final stages: row-major vertex index of each corner plus base, and output register.
// Depends on gfti_pkg, gfti_if and the assertion macro header.
`include "geosphere_face_triangle_indexer_assert.svh"

module gfti_index
    import gfti_pkg::*;
#(
    parameter int MAX_LEVEL = DEFAULT_MAX_LEVEL
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [MAX_LEVEL:0]        m,
    input  logic [IDX_W-1:0]          verts,
    input  logic                      up_valid,
    output logic                      up_ready,
    input  logic [BASE_W-1:0]         up_base,
    input  logic [2:0][MAX_LEVEL:0]   up_x,
    input  logic [2:0][MAX_LEVEL:0]   up_y,
    gfti_result_if.source             result
);

    localparam int CW = MAX_LEVEL + 1;
    localparam int TW = CW + 1;
    localparam int PW = CW + TW;
    localparam int HW = PW - 1;
    localparam int SW = (HW > IDX_W) ? HW : IDX_W;

    // product stage
    logic                   p_valid_reg, p_valid_next;
    logic [2:0][HW-1:0]     p_half_reg;
    logic [2:0][CW-1:0]     p_x_reg;
    logic [BASE_W-1:0]      p_base_reg;
    logic [2:0][PW-1:0]     prod;
    logic [TW-1:0]          two_m3;

    // output stage
    logic                   o_valid_reg, o_valid_next;
    logic [2:0][IDX_W-1:0]  o_idx_reg, o_idx_next;
    logic [IDX_W-1:0]       o_next_reg, o_next_next;
    logic                   o_adv;
    logic                   p_adv;

    assign o_adv    = !o_valid_reg || result.ready;
    assign p_adv    = !p_valid_reg || o_adv;
    assign up_ready = p_adv;

    // vertices in rows above y: y*(2m+3-y)/2
    assign two_m3 = {m, 1'b0} + TW'(3);
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            prod[c] = PW'(up_y[c]) * PW'(two_m3 - TW'(up_y[c]));
        end
    end

    // add column and face base, wrap to field width
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            o_idx_next[c] = IDX_W'(SW'(p_half_reg[c]) + SW'(p_x_reg[c]) + SW'(p_base_reg));
        end
        o_next_next = IDX_W'(p_base_reg) + verts;
    end

    assign p_valid_next = p_adv ? up_valid : p_valid_reg;
    assign o_valid_next = o_adv ? p_valid_reg : o_valid_reg;

    // handshake state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= p_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    // word registers
    always_ff @(posedge clk)
    begin
        if (p_adv && up_valid)
        begin
            for (int c = 0; c < 3; c++)
            begin
                p_half_reg[c] <= prod[c][PW-1:1];
            end
            p_x_reg    <= up_x;
            p_base_reg <= up_base;
        end
        if (o_adv && p_valid_reg)
        begin
            o_idx_reg  <= o_idx_next;
            o_next_reg <= o_next_next;
        end
    end

    assign result.valid           = o_valid_reg;
    assign result.corner_a_index  = o_idx_reg[0];
    assign result.corner_b_index  = o_idx_reg[1];
    assign result.corner_c_index  = o_idx_reg[2];
    assign result.next_base_index = o_next_reg;

    // product stage holds its word while the output register is blocked
    `GFTI_ASSERT_NEXT(a_idx_hold, p_valid_reg && !o_adv, p_valid_reg && $stable(p_half_reg) && $stable(p_base_reg))

endmodule

>>> rtl/geosphere_face_triangle_indexer.sv
// Top level of the geosphere face triangle indexer: config register, digit chain, index stages.
// Depends on gfti_pkg, gfti_if, gfti_cell and gfti_index.
//
// Usage:
//   item   : input words (triangle_number, base_index), valid/ready.
//   result : output words (corner_a/b/c_index, next_base_index), valid/ready.
//   cfg_we/cfg_wdata : write of the resolution register, taken on any edge
//     with cfg_we high; write it only while no word is in flight.
// Each word passes through MAX_LEVEL digit cells (one base-4 digit each),
// one product stage and one output register between acceptance and result
// valid. Throughput is one word per cycle while result.ready stays high;
// each cell and stage has its own valid bit and local ready.
// When the receiver stalls, words back up stage by stage; item.ready falls
// only once the first cell is full and blocked. Bubbles are squeezed out.
// Reset clears all valid bits and loads resolution 5; no clearing pass.
// Resolution above MAX_LEVEL saturates; outputs wrap to 18 bits.
module geosphere_face_triangle_indexer
    import gfti_pkg::*;
#(
    parameter int MAX_LEVEL = DEFAULT_MAX_LEVEL
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [RES_W-1:0]  cfg_wdata,
    gfti_item_if.sink         item,
    gfti_result_if.source     result
);

    localparam int CW    = MAX_LEVEL + 1;
    localparam int LVL_W = $clog2(MAX_LEVEL + 1);
    localparam int VW    = (2 * CW + 2 > IDX_W + 1) ? 2 * CW + 2 : IDX_W + 1;

    logic [RES_W-1:0]   resolution_reg, resolution_next;
    logic [IDX_W-1:0]   verts_reg, verts_next;
    logic [LVL_W-1:0]   lvl;
    logic [CW-1:0]      m;
    logic [VW-1:0]      verts_prod;

    // chain links between cells
    logic                       ch_valid [MAX_LEVEL+1];
    logic                       ch_ready [MAX_LEVEL+1];
    logic [TN_W-1:0]            ch_tn    [MAX_LEVEL+1];
    logic [BASE_W-1:0]          ch_base  [MAX_LEVEL+1];
    logic [2:0][CW-1:0]         ch_x     [MAX_LEVEL+1];
    logic [2:0][CW-1:0]         ch_y     [MAX_LEVEL+1];

    // resolution register
    assign resolution_next = cfg_we ? cfg_wdata : resolution_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resolution_reg <= RES_RESET;
        end
        else
        begin
            resolution_reg <= resolution_next;
        end
    end

    // saturated level, edge length and vertex count of a face
    assign lvl = (int'(resolution_reg) > MAX_LEVEL) ? LVL_W'(MAX_LEVEL)
                                                    : LVL_W'(resolution_reg);
    assign m          = CW'(1) << lvl;
    assign verts_prod = (VW'(m) + VW'(1)) * (VW'(m) + VW'(2));
    assign verts_next = verts_prod[IDX_W:1];

    always_ff @(posedge clk)
    begin
        verts_reg <= verts_next;
    end

    // unit triangle enters the chain: a (0,0), b (1,0), c (0,1)
    assign ch_valid[0] = item.valid;
    assign item.ready  = ch_ready[0];
    assign ch_tn[0]    = item.triangle_number;
    assign ch_base[0]  = item.base_index;
    assign ch_x[0]     = {CW'(0), CW'(1), CW'(0)};
    assign ch_y[0]     = {CW'(1), CW'(0), CW'(0)};

    // digit cells, least significant digit first
    generate
        for (genvar i = 0; i < MAX_LEVEL; i++)
        begin : g_cell
            gfti_cell #(
                .MAX_LEVEL (MAX_LEVEL),
                .IDX       (i)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .lvl      (lvl),
                .up_valid (ch_valid[i]),
                .up_ready (ch_ready[i]),
                .up_tn    (ch_tn[i]),
                .up_base  (ch_base[i]),
                .up_x     (ch_x[i]),
                .up_y     (ch_y[i]),
                .dn_valid (ch_valid[i+1]),
                .dn_ready (ch_ready[i+1]),
                .dn_tn    (ch_tn[i+1]),
                .dn_base  (ch_base[i+1]),
                .dn_x     (ch_x[i+1]),
                .dn_y     (ch_y[i+1])
            );
        end
    endgenerate

    // vertex index stages and output register
    gfti_index #(
        .MAX_LEVEL (MAX_LEVEL)
    ) u_index (
        .clk      (clk),
        .rst_n    (rst_n),
        .m        (m),
        .verts    (verts_reg),
        .up_valid (ch_valid[MAX_LEVEL]),
        .up_ready (ch_ready[MAX_LEVEL]),
        .up_base  (ch_base[MAX_LEVEL]),
        .up_x     (ch_x[MAX_LEVEL]),
        .up_y     (ch_y[MAX_LEVEL]),
        .result   (result)
    );

endmodule

>>> dv/geosphere_face_triangle_indexer_tb.sv
// Self-checking bench for the geosphere face triangle indexer: predicts corner indices per word.
// Depends on gfti_pkg, gfti_if and the RTL top level geosphere_face_triangle_indexer.
module geosphere_face_triangle_indexer_tb;
    import gfti_pkg::*;

    localparam int LEVEL_CAP       = DEFAULT_MAX_LEVEL;
    localparam int LATENCY         = LEVEL_CAP + 2;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int RANDOM_PHASES   = 10;
    localparam int WORDS_PER_PHASE = 100;
    localparam int HOLD_OFF_CYCLES = 250;

    // one result word as the predictor sees it
    typedef struct packed {
        logic [IDX_W-1:0] corner_a;
        logic [IDX_W-1:0] corner_b;
        logic [IDX_W-1:0] corner_c;
        logic [IDX_W-1:0] next_base;
    } corner_set_t;

    // receiver behaviour over one stretch
    typedef enum logic [1:0] {
        RX_FLOW,
        RX_MOSTLY,
        RX_SPARSE,
        RX_PAUSE
    } rx_mode_t;

    // Predicted corner indices, checked in order of arrival
    class corner_index_scoreboard;
        logic [RES_W-1:0] resolution;
        corner_set_t      expected_corners[$];
        int unsigned      errors;

        function new();
            resolution = RES_RESET;
            errors     = 0;
        endfunction

        // row-major slot of grid point (x,y) on a face with m segments per edge
        function int unsigned vertex_slot(int unsigned x, int unsigned y, int unsigned m);
            int unsigned rows_left;
            rows_left = m - y;
            return x + (m + 1) * (m + 2) / 2 - (rows_left + 1) * (rows_left + 2) / 2;
        endfunction

        function corner_set_t predict_corners(logic [TN_W-1:0] tn, logic [BASE_W-1:0] base);
            int unsigned lvl;
            int unsigned m;
            int unsigned k;
            int          n;
            int          ax, ay, bx, by, cx, cy;
            int          stride, f, ox, oy;
            digit_t      d;
            corner_set_t r;
            lvl = (resolution > LEVEL_CAP) ? LEVEL_CAP : resolution;
            m   = 1 << lvl;
            k   = tn & ((1 << (2 * lvl)) - 1);
            ax = 0; ay = 0; bx = 1; by = 0; cx = 0; cy = 1;
            stride = 1;
            // least significant digit first; each level doubles the scale
            for (n = 0; n < lvl; n++)
            begin
                d = digit_t'(2'(k >> (2 * n)));
                f = 1; ox = 0; oy = 0;
                case (d)
                    DIG_BASE:  ;
                    DIG_UP:    oy = stride;
                    DIG_MID:
                    begin
                        f  = -1;
                        ox = stride;
                        oy = stride;
                    end
                    DIG_RIGHT: ox = stride;
                endcase
                ax = ax * f + ox; ay = ay * f + oy;
                bx = bx * f + ox; by = by * f + oy;
                cx = cx * f + ox; cy = cy * f + oy;
                stride = stride * 2;
            end
            r.corner_a  = IDX_W'(vertex_slot(ax, ay, m) + base);
            r.corner_b  = IDX_W'(vertex_slot(bx, by, m) + base);
            r.corner_c  = IDX_W'(vertex_slot(cx, cy, m) + base);
            r.next_base = IDX_W'((m + 1) * (m + 2) / 2 + base);
            return r;
        endfunction

        function void note_triangle(logic [TN_W-1:0] tn, logic [BASE_W-1:0] base);
            expected_corners.push_back(predict_corners(tn, base));
        endfunction

        function void check_corners(corner_set_t got);
            corner_set_t want;
            if (expected_corners.size() == 0)
            begin
                $error("result word with no expectation pending");
                errors++;
                return;
            end
            want = expected_corners.pop_front();
            if (got.corner_a !== want.corner_a)
            begin
                $error("corner_a_index expected %0d got %0d", want.corner_a, got.corner_a);
                errors++;
            end
            if (got.corner_b !== want.corner_b)
            begin
                $error("corner_b_index expected %0d got %0d", want.corner_b, got.corner_b);
                errors++;
            end
            if (got.corner_c !== want.corner_c)
            begin
                $error("corner_c_index expected %0d got %0d", want.corner_c, got.corner_c);
                errors++;
            end
            if (got.next_base !== want.next_base)
            begin
                $error("next_base_index expected %0d got %0d", want.next_base, got.next_base);
                errors++;
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [RES_W-1:0] cfg_wdata;
    logic             hold_req;

    gfti_item_if   item_ch();
    gfti_result_if result_ch();

    corner_index_scoreboard board;

    int       cycle_count  = 0;
    int       hold_left    = 0;
    int       stretch_left = 0;
    bit       hold_taken   = 1'b0;
    rx_mode_t rx_mode      = RX_FLOW;

    geosphere_face_triangle_indexer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item_ch),
        .result    (result_ch)
    );

    always #5 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("geosphere_face_triangle_indexer verification failed");
            $finish;
        end
    end

    // Receiver: check accepted words, then pick next ready value
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            board.check_corners(corner_set_t'{result_ch.corner_a_index,
                                              result_ch.corner_b_index,
                                              result_ch.corner_c_index,
                                              result_ch.next_base_index});
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left       <= hold_left - 1;
            result_ch.ready <= 1'b0;
        end
        else if (hold_req && !hold_taken)
        begin
            // one long hold-off so the cell row fills and item.ready drops
            hold_taken      <= 1'b1;
            hold_left       <= HOLD_OFF_CYCLES;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (stretch_left == 0)
            begin
                rx_mode      <= rx_mode_t'($urandom_range(0, 3));
                stretch_left <= $urandom_range(10, 80);
            end
            else
                stretch_left <= stretch_left - 1;
            case (rx_mode)
                RX_FLOW:   result_ch.ready <= 1'b1;
                RX_MOSTLY: result_ch.ready <= ($urandom_range(0, 3) != 0);
                RX_SPARSE: result_ch.ready <= ($urandom_range(0, 3) == 0);
                RX_PAUSE:  result_ch.ready <= 1'b0;
            endcase
        end
    end

    // Offer one word and hold it until taken
    task automatic send_triangle(input logic [TN_W-1:0] tn, input logic [BASE_W-1:0] base);
        item_ch.valid           <= 1'b1;
        item_ch.triangle_number <= tn;
        item_ch.base_index      <= base;
        do
            @(posedge clk);
        while (!item_ch.ready);
        board.note_triangle(tn, base);
    endtask

    task automatic idle_sender(input int cycles);
        item_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Register write once the pipe has drained
    task automatic write_resolution(input logic [RES_W-1:0] res);
        item_ch.valid <= 1'b0;
        while (board.expected_corners.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= res;
        @(posedge clk);
        cfg_we           <= 1'b0;
        board.resolution  = res;
    endtask

    // Mostly in-range numbers, the rest anywhere in the 16-bit field
    function automatic logic [TN_W-1:0] pick_triangle();
        int unsigned lvl;
        lvl = (board.resolution > LEVEL_CAP) ? LEVEL_CAP : board.resolution;
        if ($urandom_range(0, 3) != 0)
            return TN_W'($urandom_range(0, (1 << (2 * lvl)) - 1));
        return TN_W'($urandom);
    endfunction

    function automatic logic [BASE_W-1:0] pick_base();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return BASE_W'($urandom);
        endcase
    endfunction

    // Bursts of random length with random gaps
    task automatic send_random_words(input int count);
        int burst_left;
        int gap;
        int sent;
        burst_left = $urandom_range(1, 40);
        for (sent = 0; sent < count; sent++)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(0, 12);
                if (gap != 0)
                    idle_sender(gap);
                burst_left = $urandom_range(1, 40);
            end
            send_triangle(pick_triangle(), pick_base());
            burst_left--;
        end
    endtask

    logic [RES_W-1:0] phase_res [RANDOM_PHASES] =
        '{4'd5, 4'd8, 4'd0, 4'd15, 4'd3, 4'd6, 4'd1, 4'd12, 4'd7, 4'd4};

    // Main sequence
    initial
    begin
        int p;
        board                    = new();
        rst_n                   <= 1'b0;
        cfg_we                  <= 1'b0;
        cfg_wdata               <= '0;
        hold_req                <= 1'b0;
        item_ch.valid           <= 1'b0;
        item_ch.triangle_number <= '0;
        item_ch.base_index      <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset level 5: extremes, last in-range number and first wrapped one
        send_triangle(16'h0000, 17'h00000);
        send_triangle(16'hFFFF, 17'h1FFFF);
        send_triangle(16'h03FF, 17'd99459);
        send_triangle(16'h0400, 17'd12);

        // level 0: a face of one triangle
        write_resolution(4'd0);
        send_triangle(16'h0000, 17'h00000);
        send_triangle(16'hFFFF, 17'h1FFFF);

        // full depth: every digit value in every position
        write_resolution(4'd8);
        send_triangle(16'h0000, 17'h00000);
        send_triangle(16'hFFFF, 17'h1FFFF);
        send_triangle(16'h5555, 17'd1);
        send_triangle(16'hAAAA, 17'd2);
        send_triangle(16'h1B1B, 17'h10000);
        send_triangle(16'hE4E4, 17'h0FFFF);

        // level beyond the cap saturates
        write_resolution(4'd15);
        send_triangle(16'hFFFF, 17'h00000);
        send_triangle(16'h1B1B, 17'd5);

        // level 2: last in-range, wrap, reflected digit in both positions
        write_resolution(4'd2);
        send_triangle(16'd15, 17'd0);
        send_triangle(16'd16, 17'd0);
        send_triangle(16'h000B, 17'd3);
        send_triangle(16'h000E, 17'd3);

        // random phases; the first one also carries the long receiver hold-off
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            write_resolution(phase_res[p]);
            if (p == 0)
                hold_req <= 1'b1;
            send_random_words(WORDS_PER_PHASE);
        end

        // drain
        item_ch.valid <= 1'b0;
        while (board.expected_corners.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        if (board.errors == 0 && board.expected_corners.size() == 0)
            $display("geosphere_face_triangle_indexer verification clean");
        else
            $display("geosphere_face_triangle_indexer verification failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/gfti_pkg.sv
rtl/gfti_if.sv
rtl/gfti_cell.sv
rtl/gfti_index.sv
rtl/geosphere_face_triangle_indexer.sv
dv/geosphere_face_triangle_indexer_tb.sv
